// ===== sv/scpd_pkg.sv =====
// Shared types and constants for the byte-serial packet deframer.
// No dependencies; imported by the deframer top level, the state machine, the checker and the bench.

package scpd_pkg;

	localparam logic [7:0] HEADER_RESET = 8'd170;

	// result kind codes
	localparam logic [1:0] KIND_LEN  = 2'd0;
	localparam logic [1:0] KIND_DATA = 2'd1;
	localparam logic [1:0] KIND_END  = 2'd2;

	typedef enum logic [4:0] {
		PH_HUNT = 5'b00001,
		PH_ID   = 5'b00010,
		PH_LEN  = 5'b00100,
		PH_DATA = 5'b01000,
		PH_CSUM = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] payload_byte;
		logic [7:0] byte_index;
		logic [7:0] sender_id;
		logic       checksum_ok;
		logic       last;
	} result_t;

	// what the framing logic hands to the result register for one byte
	typedef struct packed {
		logic    emit;
		result_t res;
	} step_out_t;

endpackage

// ===== sv/scpd_rx_if.sv =====
// Receive byte channel: valid/ready handshake carrying one received byte.
// No dependencies.

interface scpd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== sv/scpd_res_if.sv =====
// Result channel: valid/ready handshake carrying one deframer result.
// No dependencies.

interface scpd_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] payload_byte;
	logic [7:0] byte_index;
	logic [7:0] sender_id;
	logic       checksum_ok;
	logic       last;

	modport source (output valid, output kind, output payload_byte, output byte_index,
		output sender_id, output checksum_ok, output last, input ready);
	modport sink (input valid, input kind, input payload_byte, input byte_index,
		input sender_id, input checksum_ok, input last, output ready);
endinterface

// ===== sv/sum_checksum_packet_deframer.sv =====
// Top level of the byte-serial packet deframer with 8-bit additive checksum.
// Depends on scpd_pkg, scpd_rx_if, scpd_res_if and scpd_fsm.
//
// Received bytes enter on rx, one per transfer, and may arrive in every cycle.
// Each byte is captured in an input register; from there the framing
// state machine consumes it and any result it yields lands in the result
// register on res. Sustained rate is one byte per cycle; the only thing that
// slows it is res.ready low while a result is held, which stalls the input
// register and drops rx.ready. Header, ID and dropped hunt bytes
// that yield no result never wait on res. The header byte register (reset
// 0xAA) is written through cfg_we/cfg_wdata and should only be changed while
// no byte is in flight; a write mid-packet takes effect at the next header hunt.

module sum_checksum_packet_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	scpd_rx_if.sink     rx,
	scpd_res_if.source  res
);
	import scpd_pkg::*;

	logic [7:0] header_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       res_valid_q;
	result_t    res_q;
	step_out_t  fsm_o;
	logic       advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			header_q <= HEADER_RESET;
		else if (cfg_we)
			header_q <= cfg_wdata;
	end

	// the held byte moves on unless it yields a result and res is still full
	assign advance  = valid_s1 && (!fsm_o.emit || !res_valid_q || res.ready);
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (rx.ready)
			valid_s1 <= rx.valid;
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready)
			byte_s1 <= rx.rx_byte;
	end

	scpd_fsm u_fsm (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.rx_byte      (byte_s1),
		.header_value (header_q),
		.o            (fsm_o)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (advance && fsm_o.emit)
			res_valid_q <= 1'b1;
		else if (res.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && fsm_o.emit)
			res_q <= fsm_o.res;
	end

	assign res.valid        = res_valid_q;
	assign res.kind         = res_q.kind;
	assign res.payload_byte = res_q.payload_byte;
	assign res.byte_index   = res_q.byte_index;
	assign res.sender_id    = res_q.sender_id;
	assign res.checksum_ok  = res_q.checksum_ok;
	assign res.last         = res_q.last;

endmodule

// ===== sv/scpd_fsm.sv =====
// Framing state machine: header hunt, ID, length, data and checksum phases.
// Depends on scpd_pkg. One byte is consumed on each cycle with step high.

module scpd_fsm (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           rx_byte,
	input  logic [7:0]           header_value,
	output scpd_pkg::step_out_t  o
);
	import scpd_pkg::*;

	phase_t     phase_q, phase_d;
	logic [7:0] packet_id_q, packet_id_d;
	logic [7:0] bytes_left_q, bytes_left_d;
	logic [7:0] data_pos_q, data_pos_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] left_dec;

	assign left_dec = bytes_left_q - 8'd1;

	always_comb begin
		phase_d      = phase_q;
		packet_id_d  = packet_id_q;
		bytes_left_d = bytes_left_q;
		data_pos_d   = data_pos_q;
		sum_d        = sum_q;
		o            = '0;
		o.res.sender_id = packet_id_q;
		unique case (phase_q)
			PH_ID: begin
				packet_id_d = rx_byte;
				sum_d       = rx_byte;
				phase_d     = PH_LEN;
			end
			PH_LEN: begin
				sum_d              = sum_q + rx_byte;
				bytes_left_d       = rx_byte;
				data_pos_d         = 8'd0;
				phase_d            = (rx_byte == 8'd0) ? PH_CSUM : PH_DATA;
				o.emit             = 1'b1;
				o.res.kind         = KIND_LEN;
				o.res.payload_byte = rx_byte;
			end
			PH_DATA: begin
				sum_d              = sum_q + rx_byte;
				data_pos_d         = data_pos_q + 8'd1;
				bytes_left_d       = left_dec;
				if (left_dec == 8'd0)
					phase_d = PH_CSUM;
				o.emit             = 1'b1;
				o.res.kind         = KIND_DATA;
				o.res.payload_byte = rx_byte;
				o.res.byte_index   = data_pos_q;
			end
			PH_CSUM: begin
				phase_d           = PH_HUNT;
				o.emit            = 1'b1;
				o.res.kind        = KIND_END;
				o.res.checksum_ok = (rx_byte == sum_q);
				o.res.last        = 1'b1;
			end
			default: begin
				// hunting: anything but the header byte is dropped
				phase_d = (rx_byte == header_value) ? PH_ID : PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			packet_id_q  <= 8'd0;
			bytes_left_q <= 8'd0;
			data_pos_q   <= 8'd0;
			sum_q        <= 8'd0;
		end else if (step) begin
			phase_q      <= phase_d;
			packet_id_q  <= packet_id_d;
			bytes_left_q <= bytes_left_d;
			data_pos_q   <= data_pos_d;
			sum_q        <= sum_d;
		end
	end

endmodule

// ===== sv/scpd_checker.sv =====
// Port-level checks on the deframer result channel, bound to the top level.
// Depends on scpd_pkg and sum_checksum_packet_deframer.

module scpd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [1:0] res_kind,
	input logic [7:0] res_payload_byte,
	input logic [7:0] res_byte_index,
	input logic [7:0] res_sender_id,
	input logic       res_checksum_ok,
	input logic       res_last
);
	import scpd_pkg::*;

	// a stalled result must hold
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_kind) &&
		$stable(res_payload_byte) && $stable(res_byte_index) &&
		$stable(res_sender_id) && $stable(res_checksum_ok) && $stable(res_last))
		else $error("result changed while stalled");

	a_last_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_last == (res_kind == KIND_END)))
		else $error("last flag disagrees with kind");

	a_ok_only_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind != KIND_END |-> !res_checksum_ok)
		else $error("checksum flag on a non-status result");

	a_end_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_kind == KIND_END || res_kind == KIND_LEN)
		|-> res_byte_index == 8'd0 &&
		(res_kind == KIND_LEN || res_payload_byte == 8'd0))
		else $error("status or length result carries stray fields");

endmodule

bind sum_checksum_packet_deframer scpd_checker u_scpd_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_kind         (res.kind),
	.res_payload_byte (res.payload_byte),
	.res_byte_index   (res.byte_index),
	.res_sender_id    (res.sender_id),
	.res_checksum_ok  (res.checksum_ok),
	.res_last         (res.last)
);

// ===== bench/tb_sum_checksum_packet_deframer.sv =====
// Self-checking bench for sum_checksum_packet_deframer: byte stream in, framed results out.
// Depends on scpd_pkg, scpd_rx_if, scpd_res_if and the deframer RTL; a scoreboard class
// predicts every result from the accepted bytes and checks them in order.

module tb_sum_checksum_packet_deframer;
	import scpd_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int ITEMS        = 1150;
	localparam int LONG_HOLD    = 80;
	localparam int SETTLE       = 4;
	localparam int DRAIN_LIMIT  = 5000;

	class deframe_scoreboard;
		logic [7:0]  header_byte;
		phase_t      frame_phase;
		logic [7:0]  cur_id;
		logic [7:0]  bytes_to_go;
		logic [7:0]  data_pos;
		logic [7:0]  csum_acc;
		result_t     awaited_results[$];
		int unsigned mismatches;
		int unsigned byte_count;
		int unsigned result_count;
		int unsigned good_packets;
		int unsigned bad_packets;

		function new();
			header_byte  = HEADER_RESET;
			frame_phase  = PH_HUNT;
			cur_id       = '0;
			bytes_to_go  = '0;
			data_pos     = '0;
			csum_acc     = '0;
			mismatches   = 0;
			byte_count   = 0;
			result_count = 0;
			good_packets = 0;
			bad_packets  = 0;
		endfunction

		function void set_header(logic [7:0] v);
			header_byte = v;
		endfunction

		function int unsigned pending();
			return awaited_results.size();
		endfunction

		function void push_result(logic [1:0] k, logic [7:0] pb, logic [7:0] idx,
			logic ok, logic lst);
			result_t r;
			r.kind         = k;
			r.payload_byte = pb;
			r.byte_index   = idx;
			r.sender_id    = cur_id;
			r.checksum_ok  = ok;
			r.last         = lst;
			awaited_results.push_back(r);
		endfunction

		// advance the framing state by one accepted byte
		function void note_byte(logic [7:0] b);
			byte_count++;
			case (frame_phase)
				PH_ID: begin
					cur_id      = b;
					csum_acc    = b;
					frame_phase = PH_LEN;
				end
				PH_LEN: begin
					csum_acc    = csum_acc + b;
					bytes_to_go = b;
					data_pos    = '0;
					frame_phase = (b == 8'd0) ? PH_CSUM : PH_DATA;
					push_result(KIND_LEN, b, 8'd0, 1'b0, 1'b0);
				end
				PH_DATA: begin
					csum_acc = csum_acc + b;
					push_result(KIND_DATA, b, data_pos, 1'b0, 1'b0);
					data_pos    = data_pos + 8'd1;
					bytes_to_go = bytes_to_go - 8'd1;
					if (bytes_to_go == 8'd0)
						frame_phase = PH_CSUM;
				end
				PH_CSUM: begin
					push_result(KIND_END, 8'd0, 8'd0, b == csum_acc, 1'b1);
					if (b == csum_acc)
						good_packets++;
					else
						bad_packets++;
					frame_phase = PH_HUNT;
				end
				default: begin
					frame_phase = (b == header_byte) ? PH_ID : PH_HUNT;
				end
			endcase
		endfunction

		function void compare_field(string name, int unsigned exp_v, int unsigned got_v);
			if (exp_v != got_v) begin
				$error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
				mismatches++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			result_count++;
			if (awaited_results.size() == 0) begin
				$error("result with nothing awaited: kind %0d payload_byte %0d sender_id %0d",
					got.kind, got.payload_byte, got.sender_id);
				mismatches++;
				return;
			end
			want = awaited_results.pop_front();
			compare_field("kind", want.kind, got.kind);
			compare_field("payload_byte", want.payload_byte, got.payload_byte);
			compare_field("byte_index", want.byte_index, got.byte_index);
			compare_field("sender_id", want.sender_id, got.sender_id);
			compare_field("checksum_ok", want.checksum_ok, got.checksum_ok);
			compare_field("last", want.last, got.last);
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;

	scpd_rx_if  rx_if();
	scpd_res_if res_if();

	deframe_scoreboard sb = new();

	bit         src_jittery;
	bit         sink_jittery;
	bit         long_hold_req;
	logic [7:0] cur_header;
	int unsigned header_writes;

	sum_checksum_packet_deframer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rx        (rx_if),
		.res       (res_if)
	);

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	// result monitor
	always @(posedge clk) begin : result_monitor
		result_t got;
		if (arst_n && res_if.valid && res_if.ready) begin
			got.kind         = res_if.kind;
			got.payload_byte = res_if.payload_byte;
			got.byte_index   = res_if.byte_index;
			got.sender_id    = res_if.sender_id;
			got.checksum_ok  = res_if.checksum_ok;
			got.last         = res_if.last;
			sb.check_result(got);
		end
	end

	// result sink: per-transfer random stall, plus one long hold on request
	initial begin : result_sink
		int unsigned gap;
		res_if.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (long_hold_req) begin
				gap = LONG_HOLD;
				long_hold_req = 1'b0;
			end else begin
				gap = sink_jittery ? $urandom_range(0, 7) : 0;
			end
			if (gap > 0) begin
				res_if.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (!(res_if.valid && res_if.ready));
			@(negedge clk);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		gap = src_jittery ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			rx_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_if.valid   <= 1'b1;
		rx_if.rx_byte <= b;
		do @(posedge clk); while (!(rx_if.valid && rx_if.ready));
		sb.note_byte(b);
		@(negedge clk);
	endtask

	// stop sending, wait for every awaited result, then let the pipeline empty
	task automatic wait_results();
		int unsigned spent;
		spent = 0;
		rx_if.valid <= 1'b0;
		while (sb.pending() != 0 && spent < DRAIN_LIMIT) begin
			@(negedge clk);
			spent++;
		end
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_header(input logic [7:0] v);
		cfg_wdata <= v;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sb.set_header(v);
		cur_header = v;
		header_writes++;
	endtask

	task automatic send_packet(input logic [7:0] id, input logic [7:0] len, input bit good);
		logic [7:0] sum;
		logic [7:0] d;
		send_byte(cur_header);
		send_byte(id);
		send_byte(len);
		sum = id + len;
		for (int i = 0; i < len; i++) begin
			d = ($urandom_range(0, 7) == 0) ? cur_header : 8'($urandom_range(0, 255));
			sum = sum + d;
			send_byte(d);
		end
		send_byte(good ? sum : sum ^ 8'($urandom_range(1, 255)));
	endtask

	initial begin : stimulus
		int unsigned phase_no;
		int unsigned pick;
		logic [7:0]  len;

		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = 8'd0;
		rx_if.valid   = 1'b0;
		rx_if.rx_byte = 8'd0;
		src_jittery   = 1'b1;
		sink_jittery  = 1'b1;
		long_hold_req = 1'b0;
		cur_header    = HEADER_RESET;
		header_writes = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset header: bytes that do not match are dropped
		send_byte(8'h00);
		send_byte(8'hFF);
		// zero length, all-zero packet with good checksum
		send_byte(HEADER_RESET);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h00);
		// header-valued data byte, wrong checksum
		send_byte(HEADER_RESET);
		send_byte(8'hFF);
		send_byte(8'h01);
		send_byte(HEADER_RESET);
		send_byte(8'h55);
		wait_results();

		write_header(8'h00);
		send_byte(8'h01);
		send_byte(8'h00);
		send_byte(8'h7F);
		send_byte(8'h02);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h80);

		// header changed mid-packet: only the next hunt sees it
		send_byte(8'h00);
		send_byte(8'h80);
		send_byte(8'h01);
		wait_results();
		write_header(8'hFF);
		send_byte(8'h00);
		send_byte(8'h81);

		// longest payload once
		send_packet(8'($urandom_range(0, 255)), 8'd255, 1'b1);

		phase_no = 0;
		while (sb.byte_count < ITEMS) begin
			wait_results();
			case (phase_no % 4)
				0:       write_header(8'h00);
				1:       write_header(8'hFF);
				2:       write_header(HEADER_RESET);
				default: write_header(8'($urandom_range(0, 255)));
			endcase
			src_jittery  = ($urandom_range(0, 3) != 0);
			sink_jittery = ($urandom_range(0, 3) != 0);
			if (phase_no == 2) begin
				// sender streams flat out while the sink holds off
				src_jittery   = 1'b0;
				long_hold_req = 1'b1;
			end
			repeat ($urandom_range(8, 16)) begin
				pick = $urandom_range(0, 99);
				if (pick < 8) begin
					repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
				end else if (pick < 16) begin
					// truncated frame: the next header lands in a later field
					send_byte(cur_header);
					send_byte(8'($urandom_range(0, 255)));
					if ($urandom_range(0, 1) != 0)
						send_byte(8'($urandom_range(0, 8)));
				end else begin
					len = ($urandom_range(0, 49) == 0) ? 8'($urandom_range(64, 255))
						: 8'($urandom_range(0, 8));
					send_packet(8'($urandom_range(0, 255)), len, $urandom_range(0, 3) != 0);
				end
			end
			phase_no++;
		end

		wait_results();
		repeat (8) @(negedge clk);
		if (sb.pending() != 0) begin
			$error("%0d results still awaited at end of run", sb.pending());
			sb.mismatches++;
		end
		$display("Run covered %0d received bytes and %0d results over %0d header settings,",
			sb.byte_count, sb.result_count, header_writes + 1);
		$display("ending %0d packets with good and %0d with bad checksums.",
			sb.good_packets, sb.bad_packets);
		if (sb.mismatches == 0) begin
			$display("tb_sum_checksum_packet_deframer passed");
		end else begin
			$display("tb_sum_checksum_packet_deframer failed");
		end
		$finish;
	end

	initial begin : watchdog
		#(CLK_PERIOD * 400000);
		$display("tb_sum_checksum_packet_deframer failed");
		$finish;
	end

endmodule
